/* sv/vdi_pkg.sv */
// package: constants, types and float compare for the vertex dedup indexer
package vdi_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_IDX_W   = 10;
    localparam int FIELD_N     = 8;
    localparam int FIELD_W     = 32;
    localparam int ENTRY_W     = FIELD_N * FIELD_W;

    // configuration register indexes
    localparam logic CFG_NORMALS   = 1'b0;
    localparam logic CFG_TEXCOORDS = 1'b1;

    typedef logic [FIELD_W-1:0] t_field;
    typedef t_field t_entry [FIELD_N];

    // word handed from cell to cell along the compare chain
    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic                 match;
        logic [IDX_W-1:0]     idx;
        logic [ENTRY_W-1:0]   entry;
    } t_tok;

    // float equality: nan never equal, +0 equals -0
    function automatic logic feq(input t_field a, input t_field b);
        logic [FIELD_W-2:0] ma;
        logic [FIELD_W-2:0] mb;
        ma = a[FIELD_W-2:0];
        mb = b[FIELD_W-2:0];
        if (ma > 31'h7F80_0000 || mb > 31'h7F80_0000) begin
            return 1'b0;
        end
        if (ma == '0 && mb == '0) begin
            return 1'b1;
        end
        return a == b;
    endfunction

endpackage

/* sv/vdi_if.sv */
// interfaces: vertex input channel and index result channel
interface vdi_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] norm_x;
    logic [31:0] norm_y;
    logic [31:0] norm_z;
    logic [31:0] tex_u;
    logic [31:0] tex_v;
    modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                    tex_u, tex_v, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  tex_u, tex_v, output ready);
endinterface

interface vdi_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  entry_idx;
    logic        was_new;
    logic        overflow;
    modport source (output valid, entry_idx, was_new, overflow, input ready);
    modport sink (input valid, entry_idx, was_new, overflow, output ready);
endinterface

/* sv/vdi_cell.sv */
// compare cell: checks one field of a stored entry and hands the word on
module vdi_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_kill,
    input  logic                  i_en,
    input  vdi_pkg::t_field       i_q,
    input  vdi_pkg::t_field       i_efield,
    input  vdi_pkg::t_tok         i_tok,
    output vdi_pkg::t_tok         o_tok
);
    vdi_pkg::t_tok r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_kill) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
        end
        r_tok.last  <= i_tok.last;
        r_tok.idx   <= i_tok.idx;
        r_tok.entry <= i_tok.entry;
        r_tok.match <= i_tok.match & (~i_en | vdi_pkg::feq(i_efield, i_q));
    end

    assign o_tok = r_tok;
endmodule

/* sv/vertex_dedup_indexer.sv */
// top level: unique vertex table with a systolic row of field compare cells
// search: ends at the first match, or after scanning all stored entries on a miss; an
//   empty table misses without a scan
// throughput: one vertex per search; table read port issues one entry per cycle and
//   eight compare cells each check one field in turn
// reset: synchronous active-low, empties the table (count to zero), clears enables;
//   table contents are not cleared, entries at or above the count are never issued to the cells
module vertex_dedup_indexer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic       i_cfg_wdata,
    vdi_in_if.sink     i_vtx,
    vdi_out_if.source  o_res
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                      r_state, n_state;
    logic                            r_norm_en, r_tex_en;
    logic [vdi_pkg::CNT_W-1:0]       r_count;
    logic [vdi_pkg::CNT_W-1:0]       r_addr;
    vdi_pkg::t_field                 r_q [vdi_pkg::FIELD_N];
    logic [vdi_pkg::ENTRY_W-1:0]     r_mem [vdi_pkg::TABLE_DEPTH];
    logic [vdi_pkg::ENTRY_W-1:0]     w_qword;
    vdi_pkg::t_tok                   r_rd;
    vdi_pkg::t_tok                   w_chain [vdi_pkg::FIELD_N+1];
    logic                            w_en [vdi_pkg::FIELD_N];
    logic [vdi_pkg::IDX_W-1:0]       r_res_idx;
    logic                            r_res_new, r_res_ovf;
    logic                            r_out_v;
    logic [vdi_pkg::OUT_IDX_W-1:0]   r_out_idx;
    logic                            r_out_new, r_out_ovf;
    logic                            w_accept, w_hit, w_miss, w_full, w_issue, w_kill;
    logic                            w_out_free;
    vdi_pkg::t_tok                   w_tail;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_en <= 1'b0;
            r_tex_en  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vdi_pkg::CFG_NORMALS:   r_norm_en <= i_cfg_wdata;
                vdi_pkg::CFG_TEXCOORDS: r_tex_en  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign i_vtx.ready = (r_state == ST_IDLE);
    assign w_accept    = i_vtx.valid & i_vtx.ready;
    assign w_tail      = w_chain[vdi_pkg::FIELD_N];
    assign w_full      = (r_count == vdi_pkg::CNT_W'(vdi_pkg::TABLE_DEPTH));
    assign w_issue     = (r_state == ST_SCAN) && (r_addr < r_count);
    // first match at the tail is the earliest entry, since entries enter in order
    assign w_hit       = (r_state == ST_SCAN) && w_tail.valid && w_tail.match;
    assign w_miss      = (r_state == ST_SCAN) && !w_hit &&
                         ((r_count == '0) || (w_tail.valid && w_tail.last));
    assign w_kill      = (r_state != ST_SCAN) || w_hit;
    assign w_out_free  = !r_out_v || o_res.ready;

    assign w_qword = {r_q[7], r_q[6], r_q[5], r_q[4], r_q[3], r_q[2], r_q[1], r_q[0]};

    // query capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_q[0] <= i_vtx.pos_x;
            r_q[1] <= i_vtx.pos_y;
            r_q[2] <= i_vtx.pos_z;
            r_q[3] <= i_vtx.norm_x;
            r_q[4] <= i_vtx.norm_y;
            r_q[5] <= i_vtx.norm_z;
            r_q[6] <= i_vtx.tex_u;
            r_q[7] <= i_vtx.tex_v;
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_miss && !w_full) begin
            r_mem[r_count[vdi_pkg::IDX_W-1:0]] <= w_qword;
        end
        r_rd.entry <= r_mem[r_addr[vdi_pkg::IDX_W-1:0]];
        r_rd.idx   <= r_addr[vdi_pkg::IDX_W-1:0];
        r_rd.last  <= (r_addr == r_count - 1'b1);
        r_rd.match <= 1'b1;
        if (!i_rst_n || w_kill) begin
            r_rd.valid <= 1'b0;
        end else begin
            r_rd.valid <= w_issue;
        end
    end

    // scan address and entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr  <= '0;
            r_count <= '0;
        end else begin
            if (w_accept) begin
                r_addr <= '0;
            end else if (w_issue) begin
                r_addr <= r_addr + 1'b1;
            end
            if (w_miss && !w_full) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // field enables: position always, normals and uv by register
    always_comb begin
        for (int k = 0; k < vdi_pkg::FIELD_N; k++) begin
            w_en[k] = (k < 3) ? 1'b1 : ((k < 6) ? r_norm_en : r_tex_en);
        end
    end

    assign w_chain[0] = r_rd;

    // row of compare cells, one field per cell
    for (genvar g = 0; g < vdi_pkg::FIELD_N; g++) begin : g_cell
        vdi_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_kill   (w_kill),
            .i_en     (w_en[g]),
            .i_q      (r_q[g]),
            .i_efield (w_chain[g].entry[g*vdi_pkg::FIELD_W +: vdi_pkg::FIELD_W]),
            .i_tok    (w_chain[g]),
            .o_tok    (w_chain[g+1])
        );
    end

    // control
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_SCAN;
            ST_SCAN: if (w_hit || w_miss) n_state = ST_DONE;
            ST_DONE: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // held result while the output word is busy
    always_ff @(posedge i_clk) begin
        if (w_hit) begin
            r_res_idx <= w_tail.idx;
            r_res_new <= 1'b0;
            r_res_ovf <= 1'b0;
        end else if (w_miss) begin
            r_res_idx <= w_full ? '0 : r_count[vdi_pkg::IDX_W-1:0];
            r_res_new <= !w_full;
            r_res_ovf <= w_full;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (r_state == ST_DONE && w_out_free) begin
            r_out_v <= 1'b1;
        end else if (o_res.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            r_out_idx <= vdi_pkg::OUT_IDX_W'(r_res_idx);
            r_out_new <= r_res_new;
            r_out_ovf <= r_res_ovf;
        end
    end

    assign o_res.valid     = r_out_v;
    assign o_res.entry_idx = r_out_idx;
    assign o_res.was_new   = r_out_new;
    assign o_res.overflow  = r_out_ovf;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= vdi_pkg::CNT_W'(vdi_pkg::TABLE_DEPTH))
        else $error("entry count above table depth");
    a_hit_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_hit && w_miss))
        else $error("hit and miss together");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count == $past(r_count) + 1'b1))
        else $error("entry count moved by other than one");
    a_res_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> !(r_res_new && r_res_ovf))
        else $error("new and overflow together");
endmodule
